/* hw/rtl/ebalu_pkg.sv */
// ----------------------------------------------------------------------------
// ebalu_pkg
// Operation codes, flag bit positions and BCD correction constants, imported by the ALU and its checker.
// ----------------------------------------------------------------------------
package ebalu_pkg;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_XOR   = 5'd5,
    OP_OR    = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_RLCA  = 5'd10,
    OP_RRCA  = 5'd11,
    OP_RLA   = 5'd12,
    OP_RRA   = 5'd13,
    OP_DAA   = 5'd14,
    OP_CPL   = 5'd15,
    OP_SCF   = 5'd16,
    OP_RLC   = 5'd17,
    OP_RL    = 5'd18,
    OP_RR    = 5'd19,
    OP_SLA   = 5'd20,
    OP_SWAP  = 5'd21,
    OP_SRL   = 5'd22,
    OP_BIT   = 5'd23,
    OP_RES   = 5'd24,
    OP_SET   = 5'd25,
    OP_ADDHL = 5'd26,
    OP_ADDSP = 5'd27
  } op_t;

  // flag positions within a 4-bit flag nibble
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // BCD correction constants
  localparam logic [7:0] DAA_LO    = 8'h06;
  localparam logic [7:0] DAA_HI    = 8'h60;
  localparam logic [7:0] DAA_LIMIT = 8'h99;

endpackage

/* hw/rtl/eight_bit_cpu_alu_flags.sv */
// ----------------------------------------------------------------------------
// eight_bit_cpu_alu_flags
// Pipelined SM83-style ALU: 8-bit arithmetic, logic, rotates, BCD adjust,
// bit operations and the two 16-bit additions, with Z N H C flag update.
// ----------------------------------------------------------------------------
//
// Usage
// - Command channel: present op and its operands with start high. A beat is
//   taken at each rising edge where start is high and busy is low. busy only
//   rises while rst is held, so one beat may be issued every cycle.
// - Result channel: done is high for exactly one cycle with result,
//   result_word and flags_out. Nothing can hold it off; the consumer must
//   take the beat in that cycle.
// - Path: an accepted beat is registered in the stage 1, stage 2 and output
//   registers in turn; done rises together with its result.
// - Throughput: one beat per cycle, set by three register stages:
//     stage 1  operand preparation (subtract inversion, carry in, BCD
//              correction value, sign extension of the SP offset)
//     stage 2  the 8-bit and 16-bit adders and the logic/shift unit
//     stage 3  result selection and flag assembly into the output regs
// - Reset: synchronous rst clears all valid bits; any beats in flight are
//   dropped and no done strobe follows. busy is high during reset.
// - Unused output words read as zero; undefined op codes return zero and
//   pass the incoming flags through.
//
module eight_bit_cpu_alu_flags
  import ebalu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  op,
  input  logic [7:0]  a_val,
  input  logic [7:0]  b_val,
  input  logic [3:0]  flags_in,
  input  logic [2:0]  bit_sel,
  input  logic [15:0] word_a,
  input  logic [15:0] word_b,
  output logic        done,
  output logic [7:0]  result,
  output logic [15:0] result_word,
  output logic [3:0]  flags_out
);

  // stage 1: prepared operands
  typedef struct packed {
    logic [4:0]  op;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [3:0]  flags;
    logic [2:0]  bit_sel;
    logic [7:0]  add_x;
    logic [7:0]  add_y;
    logic        add_cin;
    logic [15:0] word_a;
    logic [15:0] word_y;
    logic        daa_c;
  } s1_t;

  // stage 2: adder outputs and logic result
  typedef struct packed {
    logic [4:0]  op;
    logic [7:0]  a;
    logic [3:0]  flags;
    logic [7:0]  sum;
    logic        sum_h;   // carry into bit 4
    logic        sum_c;   // carry out of bit 7
    logic [15:0] wsum;
    logic        wsum_h;
    logic        wsum_c;
    logic [7:0]  misc;
    logic        bit_z;
    logic        daa_c;
  } s2_t;

  logic accept;
  logic v1, v2;
  s1_t  s1, s1_next;
  s2_t  s2, s2_next;

  logic [7:0]  result_next;
  logic [15:0] result_word_next;
  logic [3:0]  flags_out_next;

  assign busy   = rst;
  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // Stage 1: operand preparation
  // --------------------------------------------------------------------------
  logic       fc, fh, fn;
  logic [7:0] daa_add, daa_sub;
  logic       daa_hi_adj;

  assign fc = flags_in[FLAG_C];
  assign fh = flags_in[FLAG_H];
  assign fn = flags_in[FLAG_N];

  // after an addition the high correction also sets carry
  assign daa_hi_adj = fc || (a_val > DAA_LIMIT);
  assign daa_add = (daa_hi_adj ? DAA_HI : 8'h00)
                 | ((fh || (a_val[3:0] > 4'd9)) ? DAA_LO : 8'h00);
  assign daa_sub = (fc ? DAA_HI : 8'h00) | (fh ? DAA_LO : 8'h00);

  always_comb begin
    s1_next         = '0;
    s1_next.op      = op;
    s1_next.a       = a_val;
    s1_next.b       = b_val;
    s1_next.flags   = flags_in;
    s1_next.bit_sel = bit_sel;
    s1_next.word_a  = word_a;
    s1_next.add_x   = a_val;
    s1_next.daa_c   = fn ? fc : daa_hi_adj;
    unique case (op_t'(op))
      OP_ADD: begin
        s1_next.add_y   = b_val;
        s1_next.add_cin = 1'b0;
      end
      OP_ADC: begin
        s1_next.add_y   = b_val;
        s1_next.add_cin = fc;
      end
      // a - b - t as a + ~b + !t; borrows come out inverted
      OP_SUB, OP_CP: begin
        s1_next.add_y   = ~b_val;
        s1_next.add_cin = 1'b1;
      end
      OP_SBC: begin
        s1_next.add_y   = ~b_val;
        s1_next.add_cin = !fc;
      end
      OP_INC: begin
        s1_next.add_y   = 8'h00;
        s1_next.add_cin = 1'b1;
      end
      OP_DEC: begin
        s1_next.add_y   = 8'hFF;
        s1_next.add_cin = 1'b0;
      end
      OP_DAA: begin
        s1_next.add_y   = fn ? ~daa_sub : daa_add;
        s1_next.add_cin = fn;
      end
      OP_ADDHL: begin
        s1_next.word_y = word_b;
      end
      OP_ADDSP: begin
        s1_next.word_y = {{8{b_val[7]}}, b_val};
      end
      default: begin
        s1_next.add_y   = 8'h00;
        s1_next.add_cin = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: adders, logic and shifter
  // --------------------------------------------------------------------------
  logic [8:0]  sum9;
  logic [16:0] sum17;
  logic [15:0] wcarry;
  logic [7:0]  bit_mask;

  assign sum9   = {1'b0, s1.add_x} + {1'b0, s1.add_y} + {8'h00, s1.add_cin};
  assign sum17  = {1'b0, s1.word_a} + {1'b0, s1.word_y};
  // carry into each bit position of the word adder
  assign wcarry = sum17[15:0] ^ s1.word_a ^ s1.word_y;
  assign bit_mask = 8'h01 << s1.bit_sel;

  always_comb begin
    s2_next        = '0;
    s2_next.op     = s1.op;
    s2_next.a      = s1.a;
    s2_next.flags  = s1.flags;
    s2_next.sum    = sum9[7:0];
    s2_next.sum_h  = sum9[4] ^ s1.add_x[4] ^ s1.add_y[4];
    s2_next.sum_c  = sum9[8];
    s2_next.wsum   = sum17[15:0];
    s2_next.bit_z  = !s1.a[s1.bit_sel];
    s2_next.daa_c  = s1.daa_c;
    // SP + offset flags come from the low byte; ADD HL from bits 11 and 15
    if (op_t'(s1.op) == OP_ADDSP) begin
      s2_next.wsum_h = wcarry[4];
      s2_next.wsum_c = wcarry[8];
    end else begin
      s2_next.wsum_h = wcarry[12];
      s2_next.wsum_c = sum17[16];
    end
    unique case (op_t'(s1.op))
      OP_AND:                         s2_next.misc = s1.a & s1.b;
      OP_XOR:                         s2_next.misc = s1.a ^ s1.b;
      OP_OR:                          s2_next.misc = s1.a | s1.b;
      OP_RLCA, OP_RLC:                s2_next.misc = {s1.a[6:0], s1.a[7]};
      OP_RRCA:                        s2_next.misc = {s1.a[0], s1.a[7:1]};
      OP_RLA, OP_RL:                  s2_next.misc = {s1.a[6:0], s1.flags[FLAG_C]};
      OP_RRA, OP_RR:                  s2_next.misc = {s1.flags[FLAG_C], s1.a[7:1]};
      OP_CPL:                         s2_next.misc = ~s1.a;
      OP_SLA:                         s2_next.misc = {s1.a[6:0], 1'b0};
      OP_SWAP:                        s2_next.misc = {s1.a[3:0], s1.a[7:4]};
      OP_SRL:                         s2_next.misc = {1'b0, s1.a[7:1]};
      OP_RES:                         s2_next.misc = s1.a & ~bit_mask;
      OP_SET:                         s2_next.misc = s1.a | bit_mask;
      default:                        s2_next.misc = s1.a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      s2 <= s2_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: result select and flag assembly
  // --------------------------------------------------------------------------
  logic z_sum, z_misc, f_z, f_c;

  assign z_sum  = (s2.sum == 8'h00);
  assign z_misc = (s2.misc == 8'h00);
  assign f_z    = s2.flags[FLAG_Z];
  assign f_c    = s2.flags[FLAG_C];

  always_comb begin
    result_next      = 8'h00;
    result_word_next = 16'h0000;
    flags_out_next   = s2.flags;
    unique case (op_t'(s2.op))
      OP_ADD, OP_ADC: begin
        result_next    = s2.sum;
        flags_out_next = {z_sum, 1'b0, s2.sum_h, s2.sum_c};
      end
      OP_SUB, OP_SBC: begin
        result_next    = s2.sum;
        flags_out_next = {z_sum, 1'b1, !s2.sum_h, !s2.sum_c};
      end
      OP_CP: begin
        result_next    = s2.a;
        flags_out_next = {z_sum, 1'b1, !s2.sum_h, !s2.sum_c};
      end
      OP_AND: begin
        result_next    = s2.misc;
        flags_out_next = {z_misc, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR, OP_OR, OP_SWAP: begin
        result_next    = s2.misc;
        flags_out_next = {z_misc, 3'b000};
      end
      OP_INC: begin
        result_next    = s2.sum;
        flags_out_next = {z_sum, 1'b0, s2.sum_h, f_c};
      end
      OP_DEC: begin
        result_next    = s2.sum;
        flags_out_next = {z_sum, 1'b1, !s2.sum_h, f_c};
      end
      OP_RLCA, OP_RLA: begin
        result_next    = s2.misc;
        flags_out_next = {3'b000, s2.a[7]};
      end
      OP_RRCA, OP_RRA: begin
        result_next    = s2.misc;
        flags_out_next = {3'b000, s2.a[0]};
      end
      OP_RLC, OP_RL, OP_SLA: begin
        result_next    = s2.misc;
        flags_out_next = {z_misc, 2'b00, s2.a[7]};
      end
      OP_RR, OP_SRL: begin
        result_next    = s2.misc;
        flags_out_next = {z_misc, 2'b00, s2.a[0]};
      end
      OP_DAA: begin
        result_next    = s2.sum;
        flags_out_next = {z_sum, s2.flags[FLAG_N], 1'b0, s2.daa_c};
      end
      OP_CPL: begin
        result_next    = s2.misc;
        flags_out_next = {f_z, 1'b1, 1'b1, f_c};
      end
      OP_SCF: begin
        result_next    = s2.a;
        flags_out_next = {f_z, 2'b00, 1'b1};
      end
      OP_BIT: begin
        result_next    = s2.a;
        flags_out_next = {s2.bit_z, 1'b0, 1'b1, f_c};
      end
      OP_RES, OP_SET: begin
        result_next    = s2.misc;
      end
      OP_ADDHL: begin
        result_word_next = s2.wsum;
        flags_out_next   = {f_z, 1'b0, s2.wsum_h, s2.wsum_c};
      end
      OP_ADDSP: begin
        result_word_next = s2.wsum;
        flags_out_next   = {2'b00, s2.wsum_h, s2.wsum_c};
      end
      default: begin
        result_next = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v2) begin
      result      <= result_next;
      result_word <= result_word_next;
      flags_out   <= flags_out_next;
    end
  end

endmodule

/* hw/rtl/ebalu_chk.sv */
// ----------------------------------------------------------------------------
// ebalu_chk
// Port-level checks on the ALU pipeline: latency and result properties.
// ----------------------------------------------------------------------------
module ebalu_chk
  import ebalu_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [4:0]  op,
  input logic [7:0]  a_val,
  input logic [7:0]  b_val,
  input logic [3:0]  flags_in,
  input logic [2:0]  bit_sel,
  input logic [15:0] word_a,
  input logic [15:0] word_b,
  input logic        done,
  input logic [7:0]  result,
  input logic [15:0] result_word,
  input logic [3:0]  flags_out
);

  // every accepted beat produces a done strobe unless reset intervenes
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 (done || $past(rst) || $past(rst, 2)))
    else $error("accepted beat produced no result");

  // no result without a matching accepted command beat
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result without a command beat");

  // only the word additions drive the 16-bit result
  a_word_zero: assert property (@(posedge clk) disable iff (rst)
    done |-> (result_word == 16'h0000) || ($past(op, 3) == OP_ADDHL)
             || ($past(op, 3) == OP_ADDSP))
    else $error("result_word nonzero for an 8-bit operation");

  // RES and SET leave the flags alone
  a_res_set_flags: assert property (@(posedge clk) disable iff (rst)
    (done && (($past(op, 3) == OP_RES) || ($past(op, 3) == OP_SET)))
      |-> (flags_out == $past(flags_in, 3)))
    else $error("RES/SET altered flags");

  // BIT returns the operand unchanged
  a_bit_passes: assert property (@(posedge clk) disable iff (rst)
    (done && ($past(op, 3) == OP_BIT)) |-> (result == $past(a_val, 3)))
    else $error("BIT changed the operand");

endmodule

bind eight_bit_cpu_alu_flags ebalu_chk u_ebalu_chk (.*);
